/* sv/i2c_master_register_access_core_macros.svh */
// Assertion macros shared by the I2C register access core.
`ifndef I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define I2CM_CHECK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("i2cm check failed");

// Checks that a condition in one cycle implies a consequence in the next.
`define I2CM_CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm next-cycle check failed");

`else

`define I2CM_CHECK(label, clk, rst, prop)
`define I2CM_CHECK_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/i2cm_pkg.sv */
// Shared types and constants of the I2C register access core.
package i2cm_pkg;

  localparam int LEN_BITS = 8;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd8;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_BYTE = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_START     = 2'd1;
  localparam logic [1:0] STATUS_ADDR_NACK = 2'd2;
  localparam logic [1:0] STATUS_DATA_NACK = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic       is_read;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] wr_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       need_byte;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic [1:0] status;
  } rsp_t;

endpackage

/* sv/i2cm_engine.sv */
// Bus sequencer: advances the I2C transaction state by one item per step.
`include "i2c_master_register_access_core_macros.svh"

module i2cm_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  i2cm_pkg::item_t      item,
  input  logic [7:0]           phase_ticks,
  output i2cm_pkg::rsp_t       rsp
);
  import i2cm_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ST_A   = 5'd1;
  localparam logic [4:0] S_ST_B   = 5'd2;
  localparam logic [4:0] S_ST_C   = 5'd3;
  localparam logic [4:0] S_RS_A   = 5'd4;
  localparam logic [4:0] S_RS_B   = 5'd5;
  localparam logic [4:0] S_RS_C   = 5'd6;
  localparam logic [4:0] S_B_LOW  = 5'd7;
  localparam logic [4:0] S_B_DATA = 5'd8;
  localparam logic [4:0] S_B_HIGH = 5'd9;
  localparam logic [4:0] S_K_LOW  = 5'd10;
  localparam logic [4:0] S_K_REL  = 5'd11;
  localparam logic [4:0] S_K_HIGH = 5'd12;
  localparam logic [4:0] S_WAIT   = 5'd13;
  localparam logic [4:0] S_R_LOW  = 5'd14;
  localparam logic [4:0] S_R_HIGH = 5'd15;
  localparam logic [4:0] S_A_LOW  = 5'd16;
  localparam logic [4:0] S_A_DATA = 5'd17;
  localparam logic [4:0] S_A_HIGH = 5'd18;
  localparam logic [4:0] S_A_END  = 5'd19;
  localparam logic [4:0] S_P_LOW  = 5'd20;
  localparam logic [4:0] S_P_SDA  = 5'd21;
  localparam logic [4:0] S_P_HIGH = 5'd22;
  localparam logic [4:0] S_P_REL  = 5'd23;

  localparam logic [1:0] K_ADDR_W = 2'd0;
  localparam logic [1:0] K_REG    = 2'd1;
  localparam logic [1:0] K_ADDR_R = 2'd2;
  localparam logic [1:0] K_DATA   = 2'd3;

  logic [4:0]          state, state_next;
  logic [7:0]          phase_count, phase_count_next;
  logic [3:0]          bit_index, bit_index_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic                latched_read, latched_read_next;
  logic [6:0]          latched_device, latched_device_next;
  logic [7:0]          latched_register, latched_register_next;
  logic                scl_drive, scl_drive_next;
  logic                sda_drive, sda_drive_next;
  logic [1:0]          last_status, last_status_next;
  logic [1:0]          byte_kind, byte_kind_next;

  logic [7:0] tick_count;
  logic [7:0] limit;
  logic       enter_en;
  logic [4:0] enter_st;
  logic       send_en;
  logic [7:0] send_val;
  logic [1:0] send_kind;
  logic       rd_start;
  logic       got_valid;
  logic [7:0] got_byte;
  logic       done;
  logic [7:0] rd_addr_byte;
  logic [7:0] wr_addr_byte;
  logic [7:0] shifted_in;
  logic [3:0] bit_inc;

  assign limit        = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign tick_count   = phase_count + 8'd1;
  assign rd_addr_byte = {latched_device, 1'b1};
  assign wr_addr_byte = {latched_device, 1'b0};
  assign shifted_in   = {shift_byte[6:0], item.sda_in};
  assign bit_inc      = bit_index + 4'd1;

  always_comb begin
    state_next            = state;
    phase_count_next      = phase_count;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    bytes_left_next       = bytes_left;
    latched_read_next     = latched_read;
    latched_device_next   = latched_device;
    latched_register_next = latched_register;
    scl_drive_next        = scl_drive;
    sda_drive_next        = sda_drive;
    last_status_next      = last_status;
    byte_kind_next        = byte_kind;
    enter_en  = 1'b0;
    enter_st  = S_IDLE;
    send_en   = 1'b0;
    send_val  = 8'd0;
    send_kind = K_ADDR_W;
    rd_start  = 1'b0;
    got_valid = 1'b0;
    got_byte  = 8'd0;
    done      = 1'b0;

    case (item.req_type)
      REQ_CMD: begin
        if (state == S_IDLE) begin
          latched_read_next     = item.is_read;
          latched_device_next   = item.dev_addr;
          latched_register_next = item.reg_addr;
          bytes_left_next       = LEN_BITS'(item.length);
          last_status_next      = STATUS_OK;
          enter_en = 1'b1;
          enter_st = S_ST_A;
        end
      end
      REQ_BYTE: begin
        if (state == S_WAIT) begin
          bytes_left_next = bytes_left - LEN_BITS'(1);
          send_en   = 1'b1;
          send_val  = item.wr_byte;
          send_kind = K_DATA;
        end
      end
      REQ_TICK: begin
        if (state != S_IDLE && state != S_WAIT) begin
          phase_count_next = tick_count;
          if (tick_count >= limit) begin
            // End of the current phase: pick the next one.
            case (state)
              S_ST_A: begin
                if (!item.sda_in) begin
                  last_status_next = STATUS_START;
                  state_next = S_IDLE;
                  done = 1'b1;
                end else begin
                  enter_en = 1'b1; enter_st = S_ST_B;
                end
              end
              S_ST_B: begin
                if (item.sda_in) begin
                  last_status_next = STATUS_START;
                  state_next = S_IDLE;
                  done = 1'b1;
                end else begin
                  enter_en = 1'b1; enter_st = S_ST_C;
                end
              end
              S_ST_C: begin
                send_en = 1'b1; send_val = wr_addr_byte; send_kind = K_ADDR_W;
              end
              S_RS_A: begin
                // Line checks are not enforced on a repeated start.
                if (!item.sda_in) begin
                  send_en = 1'b1; send_val = rd_addr_byte; send_kind = K_ADDR_R;
                end else begin
                  enter_en = 1'b1; enter_st = S_RS_B;
                end
              end
              S_RS_B: begin
                if (item.sda_in) begin
                  send_en = 1'b1; send_val = rd_addr_byte; send_kind = K_ADDR_R;
                end else begin
                  enter_en = 1'b1; enter_st = S_RS_C;
                end
              end
              S_RS_C: begin
                send_en = 1'b1; send_val = rd_addr_byte; send_kind = K_ADDR_R;
              end
              S_B_LOW: begin
                enter_en = 1'b1; enter_st = S_B_DATA;
              end
              S_B_DATA: begin
                enter_en = 1'b1; enter_st = S_B_HIGH;
              end
              S_B_HIGH: begin
                bit_index_next = bit_inc;
                enter_en = 1'b1;
                enter_st = (bit_inc >= 4'd8) ? S_K_LOW : S_B_LOW;
              end
              S_K_LOW: begin
                enter_en = 1'b1; enter_st = S_K_REL;
              end
              S_K_REL: begin
                enter_en = 1'b1; enter_st = S_K_HIGH;
              end
              S_K_HIGH: begin
                case (byte_kind)
                  K_ADDR_W: begin
                    if (item.sda_in) begin
                      last_status_next = STATUS_ADDR_NACK;
                      enter_en = 1'b1; enter_st = S_P_LOW;
                    end else begin
                      send_en = 1'b1; send_val = latched_register; send_kind = K_REG;
                    end
                  end
                  K_REG: begin
                    enter_en = 1'b1;
                    if (latched_read) enter_st = S_RS_A;
                    else enter_st = (bytes_left != '0) ? S_WAIT : S_P_LOW;
                  end
                  K_ADDR_R: begin
                    if (bytes_left != '0) rd_start = 1'b1;
                    else begin
                      enter_en = 1'b1; enter_st = S_P_LOW;
                    end
                  end
                  default: begin
                    enter_en = 1'b1;
                    if (item.sda_in) begin
                      last_status_next = STATUS_DATA_NACK;
                      enter_st = S_P_LOW;
                    end else begin
                      enter_st = (bytes_left != '0) ? S_WAIT : S_P_LOW;
                    end
                  end
                endcase
              end
              S_R_LOW: begin
                enter_en = 1'b1; enter_st = S_R_HIGH;
              end
              S_R_HIGH: begin
                shift_byte_next = shifted_in;
                bit_index_next  = bit_inc;
                enter_en = 1'b1;
                if (bit_inc >= 4'd8) begin
                  bytes_left_next = bytes_left - LEN_BITS'(1);
                  got_valid = 1'b1;
                  got_byte  = shifted_in;
                  enter_st  = S_A_LOW;
                end else begin
                  enter_st = S_R_LOW;
                end
              end
              S_A_LOW: begin
                enter_en = 1'b1; enter_st = S_A_DATA;
              end
              S_A_DATA: begin
                enter_en = 1'b1; enter_st = S_A_HIGH;
              end
              S_A_HIGH: begin
                enter_en = 1'b1; enter_st = S_A_END;
              end
              S_A_END: begin
                if (bytes_left != '0) rd_start = 1'b1;
                else begin
                  enter_en = 1'b1; enter_st = S_P_LOW;
                end
              end
              S_P_LOW: begin
                enter_en = 1'b1; enter_st = S_P_SDA;
              end
              S_P_SDA: begin
                enter_en = 1'b1; enter_st = S_P_HIGH;
              end
              S_P_HIGH: begin
                enter_en = 1'b1; enter_st = S_P_REL;
              end
              S_P_REL: begin
                state_next = S_IDLE;
                done = 1'b1;
              end
              default: begin
                state_next = S_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase

    if (send_en) begin
      shift_byte_next = send_val;
      byte_kind_next  = send_kind;
      bit_index_next  = 4'd0;
      enter_en = 1'b1;
      enter_st = S_B_LOW;
    end
    if (rd_start) begin
      shift_byte_next = 8'd0;
      bit_index_next  = 4'd0;
      enter_en = 1'b1;
      enter_st = S_R_LOW;
    end

    // Entering a phase sets its line drives.
    if (enter_en) begin
      state_next       = enter_st;
      phase_count_next = 8'd0;
      case (enter_st)
        S_ST_A, S_RS_A: begin
          sda_drive_next = 1'b1;
          scl_drive_next = 1'b1;
        end
        S_ST_B, S_ST_C, S_RS_B, S_RS_C, S_P_SDA: begin
          sda_drive_next = 1'b0;
        end
        S_B_LOW, S_K_LOW, S_WAIT, S_A_LOW, S_A_END, S_P_LOW: begin
          scl_drive_next = 1'b0;
        end
        S_B_DATA: begin
          sda_drive_next  = shift_byte_next[7];
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
        end
        S_K_REL, S_P_REL: begin
          sda_drive_next = 1'b1;
        end
        S_B_HIGH, S_K_HIGH, S_R_HIGH, S_A_HIGH, S_P_HIGH: begin
          scl_drive_next = 1'b1;
        end
        S_R_LOW: begin
          sda_drive_next = 1'b1;
          scl_drive_next = 1'b0;
        end
        S_A_DATA: begin
          // The last read byte gets a NACK.
          sda_drive_next = (bytes_left_next == '0);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rsp.scl_out   = scl_drive_next;
    rsp.sda_out   = sda_drive_next;
    rsp.busy_res  = (state_next != S_IDLE);
    rsp.need_byte = (state_next == S_WAIT);
    rsp.rd_valid  = got_valid;
    rsp.rd_byte   = got_valid ? got_byte : 8'd0;
    rsp.done_res  = done;
    rsp.status    = done ? last_status_next : STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase_count      <= 8'd0;
      bit_index        <= 4'd0;
      shift_byte       <= 8'd0;
      bytes_left       <= '0;
      latched_read     <= 1'b0;
      latched_device   <= 7'd0;
      latched_register <= 8'd0;
      scl_drive        <= 1'b1;
      sda_drive        <= 1'b1;
      last_status      <= STATUS_OK;
      byte_kind        <= K_ADDR_W;
    end else if (step) begin
      state            <= state_next;
      phase_count      <= phase_count_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      bytes_left       <= bytes_left_next;
      latched_read     <= latched_read_next;
      latched_device   <= latched_device_next;
      latched_register <= latched_register_next;
      scl_drive        <= scl_drive_next;
      sda_drive        <= sda_drive_next;
      last_status      <= last_status_next;
      byte_kind        <= byte_kind_next;
    end
  end

  `I2CM_CHECK(chk_done_idle, clk, rst, !(step && rsp.done_res) || !rsp.busy_res)
  `I2CM_CHECK(chk_rd_only_read, clk, rst, !(step && rsp.rd_valid) || latched_read)
  `I2CM_CHECK(chk_wait_only_write, clk, rst, (state != S_WAIT) || !latched_read)
  `I2CM_CHECK_NEXT(chk_hold_no_step, clk, rst, !step, $stable(state) && $stable(scl_drive))

endmodule

/* sv/i2c_master_register_access_core.sv */
// Top level of the I2C register access core: stream ports, config register, pipeline.
//
// Usage: each input item on the s_axis channel is a bus tick (tuser 0), a start
// command (tuser 1) or the next write data byte (tuser 2). A start command while
// idle latches direction, device address, register and length and begins a burst
// write or burst read; every tick outside idle and the wait for a write byte moves
// the bus sequencer by one tick, and each bus phase lasts phase_ticks ticks, or one
// tick when phase_ticks is 0. Each input item yields exactly one result item on m_axis
// with the line drives, busy, need_byte, a received byte and the completion status.
// phase_ticks is written through cfg_wen / cfg_wdata; the user writes it only while
// the core is idle, and the core itself does not enforce this. An accepted item is held
// in the input register, then its sequencer result in the result register. Throughput:
// one item per cycle while results are taken, set by the sequencer update between them.
// Reset clears both pipeline stages, releases SCL and SDA, returns the sequencer
// to idle and loads phase_ticks with 8. When the receiver stalls, the result
// register holds its item, the input register still takes one more item, and
// s_axis_tready then drops until the result is taken.
module i2c_master_register_access_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // is_read, dev_addr[6:0], reg_addr[7:0], length[7:0], wr_byte[7:0], sda_in, 7 zero bits
  input  logic [39:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_out, sda_out, busy_res, need_byte, rd_valid, rd_byte[7:0], done_res, status[1:0]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata
);
  import i2cm_pkg::*;

  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  rsp_t       out_rsp;
  rsp_t       rsp;
  logic [7:0] phase_ticks;
  logic       move;
  logic       take;
  item_t      s_item;

  assign move          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || move;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign s_item.req_type = s_axis_tuser;
  assign s_item.is_read  = s_axis_tdata[0];
  assign s_item.dev_addr = s_axis_tdata[7:1];
  assign s_item.reg_addr = s_axis_tdata[15:8];
  assign s_item.length   = s_axis_tdata[23:16];
  assign s_item.wr_byte  = s_axis_tdata[31:24];
  assign s_item.sda_in   = s_axis_tdata[32];

  i2cm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (move),
    .item        (in_item),
    .phase_ticks (phase_ticks),
    .rsp         (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      phase_ticks <= PHASE_TICKS_RESET;
    end else begin
      if (cfg_wen) begin
        phase_ticks <= cfg_wdata;
      end
      if (take) begin
        in_valid <= 1'b1;
      end else if (move) begin
        in_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= s_item;
    end
    if (move) begin
      out_rsp <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_rsp.status, out_rsp.done_res, out_rsp.rd_byte,
                          out_rsp.rd_valid, out_rsp.need_byte, out_rsp.busy_res,
                          out_rsp.sda_out, out_rsp.scl_out};

endmodule

/* test/i2c_master_register_access_core_tb.sv */
// Self-checking stream testbench for the I2C register access core.
`timescale 1ns / 1ps

module i2c_master_register_access_core_tb;
  import i2cm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS = 240;
  localparam int MAX_REPORTS = 100;

  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_START_REL, SEQ_START_SDA, SEQ_START_SCL,
    SEQ_RSTART_REL, SEQ_RSTART_SDA, SEQ_RSTART_SCL,
    SEQ_BIT_LOW, SEQ_BIT_DATA, SEQ_BIT_HIGH, SEQ_ACK_LOW, SEQ_ACK_REL, SEQ_ACK_HIGH,
    SEQ_WAIT_BYTE, SEQ_RD_LOW, SEQ_RD_HIGH,
    SEQ_MACK_LOW, SEQ_MACK_DATA, SEQ_MACK_HIGH, SEQ_MACK_END,
    SEQ_STOP_LOW, SEQ_STOP_SDA, SEQ_STOP_HIGH, SEQ_STOP_REL
  } seq_e;

  typedef enum logic [1:0] {BYTE_ADDR_WR, BYTE_REG, BYTE_ADDR_RD, BYTE_DATA} byte_kind_e;

  // How the target side answers during one transaction.
  typedef enum {FLT_NONE, FLT_BUS_LOW, FLT_NO_PULL, FLT_ADDR_NACK, FLT_DATA_NACK} fault_e;
  // SDA levels seen around the repeated START of a read.
  typedef enum {RS_CLEAN, RS_SKIP_EARLY, RS_SKIP_LATE, RS_RANDOM} rs_e;
  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} stall_e;

  typedef struct packed {
    seq_e                st;
    logic [7:0]          cnt;
    logic [3:0]          bit_n;
    logic [7:0]          shreg;
    logic [LEN_BITS-1:0] left;
    logic                rd;
    logic [6:0]          dev;
    logic [7:0]          regad;
    logic                scl;
    logic                sda;
    logic [1:0]          stat;
    byte_kind_e          kind;
    logic [7:0]          ticks;
  } engine_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // is_read, dev_addr[6:0], reg_addr[7:0], length[7:0], wr_byte[7:0], sda_in, 7 zero bits
  logic [39:0] s_axis_tdata = '0;
  // req_type[1:0]
  logic [1:0]  s_axis_tuser = REQ_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // scl_out, sda_out, busy_res, need_byte, rd_valid, rd_byte[7:0], done_res, status[1:0]
  logic [15:0] m_axis_tdata;
  logic        cfg_wen = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  engine_t pred;
  engine_t gen;
  item_t   pending_q[$];
  rsp_t    expect_q[$];
  item_t   cur;
  rsp_t    want;
  rsp_t    got;
  logic    in_taken = 1'b0;
  int      burst_left = 1;
  int      gap_left = 0;
  int      err_count = 0;
  int      results_seen = 0;
  int      work_items = 0;
  int      stall_cycles = 0;
  stall_e  rx_mode = RX_OPEN;
  int      mode_left = 0;
  int      hold_left = 0;
  logic    long_hold_done = 1'b0;
  int      rx_cyc = 0;

  i2c_master_register_access_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic engine_t engine_reset();
    engine_t e;
    e = '0;
    e.st = SEQ_IDLE;
    e.kind = BYTE_ADDR_WR;
    e.scl = 1'b1;
    e.sda = 1'b1;
    e.ticks = PHASE_TICKS_RESET;
    return e;
  endfunction

  // Enters a bus phase and applies the line drives that belong to it.
  function automatic void go(inout engine_t e, input seq_e s);
    e.st = s;
    e.cnt = '0;
    case (s)
      SEQ_START_REL, SEQ_RSTART_REL: begin
        e.sda = 1'b1;
        e.scl = 1'b1;
      end
      SEQ_START_SDA, SEQ_START_SCL, SEQ_RSTART_SDA, SEQ_RSTART_SCL, SEQ_STOP_SDA: e.sda = 1'b0;
      SEQ_BIT_LOW, SEQ_ACK_LOW, SEQ_WAIT_BYTE, SEQ_MACK_LOW, SEQ_MACK_END, SEQ_STOP_LOW:
        e.scl = 1'b0;
      SEQ_BIT_DATA: begin
        e.sda = e.shreg[7];
        e.shreg = {e.shreg[6:0], 1'b0};
      end
      SEQ_ACK_REL, SEQ_STOP_REL: e.sda = 1'b1;
      SEQ_BIT_HIGH, SEQ_ACK_HIGH, SEQ_RD_HIGH, SEQ_MACK_HIGH, SEQ_STOP_HIGH: e.scl = 1'b1;
      SEQ_RD_LOW: begin
        e.sda = 1'b1;
        e.scl = 1'b0;
      end
      SEQ_MACK_DATA: e.sda = (e.left == 0);
      default: ;
    endcase
  endfunction

  function automatic void send_byte(inout engine_t e, input logic [7:0] v,
                                    input byte_kind_e k);
    e.shreg = v;
    e.kind = k;
    e.bit_n = '0;
    go(e, SEQ_BIT_LOW);
  endfunction

  function automatic void begin_read(inout engine_t e);
    e.shreg = '0;
    e.bit_n = '0;
    go(e, SEQ_RD_LOW);
  endfunction

  // Closes the current phase; returns 1 when the transaction is over.
  function automatic logic finish_phase(inout engine_t e, input logic sda, inout rsp_t r);
    logic done;
    done = 1'b0;
    case (e.st)
      SEQ_START_REL:
        if (!sda) begin
          e.stat = STATUS_START;
          e.st = SEQ_IDLE;
          done = 1'b1;
        end else go(e, SEQ_START_SDA);
      SEQ_START_SDA:
        if (sda) begin
          e.stat = STATUS_START;
          e.st = SEQ_IDLE;
          done = 1'b1;
        end else go(e, SEQ_START_SCL);
      SEQ_START_SCL: send_byte(e, {e.dev, 1'b0}, BYTE_ADDR_WR);
      // A repeated START never fails; odd SDA levels only shorten it.
      SEQ_RSTART_REL:
        if (!sda) send_byte(e, {e.dev, 1'b1}, BYTE_ADDR_RD);
        else go(e, SEQ_RSTART_SDA);
      SEQ_RSTART_SDA:
        if (sda) send_byte(e, {e.dev, 1'b1}, BYTE_ADDR_RD);
        else go(e, SEQ_RSTART_SCL);
      SEQ_RSTART_SCL: send_byte(e, {e.dev, 1'b1}, BYTE_ADDR_RD);
      SEQ_BIT_LOW: go(e, SEQ_BIT_DATA);
      SEQ_BIT_DATA: go(e, SEQ_BIT_HIGH);
      SEQ_BIT_HIGH: begin
        e.bit_n = e.bit_n + 4'd1;
        if (e.bit_n >= 8) go(e, SEQ_ACK_LOW);
        else go(e, SEQ_BIT_LOW);
      end
      SEQ_ACK_LOW: go(e, SEQ_ACK_REL);
      SEQ_ACK_REL: go(e, SEQ_ACK_HIGH);
      SEQ_ACK_HIGH:
        case (e.kind)
          BYTE_ADDR_WR:
            if (sda) begin
              e.stat = STATUS_ADDR_NACK;
              go(e, SEQ_STOP_LOW);
            end else send_byte(e, e.regad, BYTE_REG);
          BYTE_REG:
            if (e.rd) go(e, SEQ_RSTART_REL);
            else if (e.left != 0) go(e, SEQ_WAIT_BYTE);
            else go(e, SEQ_STOP_LOW);
          BYTE_ADDR_RD:
            if (e.left != 0) begin_read(e);
            else go(e, SEQ_STOP_LOW);
          default:
            if (sda) begin
              e.stat = STATUS_DATA_NACK;
              go(e, SEQ_STOP_LOW);
            end else if (e.left != 0) go(e, SEQ_WAIT_BYTE);
            else go(e, SEQ_STOP_LOW);
        endcase
      SEQ_RD_LOW: go(e, SEQ_RD_HIGH);
      SEQ_RD_HIGH: begin
        e.shreg = {e.shreg[6:0], sda};
        e.bit_n = e.bit_n + 4'd1;
        if (e.bit_n >= 8) begin
          e.left = e.left - LEN_BITS'(1);
          r.rd_valid = 1'b1;
          r.rd_byte = e.shreg;
          go(e, SEQ_MACK_LOW);
        end else go(e, SEQ_RD_LOW);
      end
      SEQ_MACK_LOW: go(e, SEQ_MACK_DATA);
      SEQ_MACK_DATA: go(e, SEQ_MACK_HIGH);
      SEQ_MACK_HIGH: go(e, SEQ_MACK_END);
      SEQ_MACK_END:
        if (e.left != 0) begin_read(e);
        else go(e, SEQ_STOP_LOW);
      SEQ_STOP_LOW: go(e, SEQ_STOP_SDA);
      SEQ_STOP_SDA: go(e, SEQ_STOP_HIGH);
      SEQ_STOP_HIGH: go(e, SEQ_STOP_REL);
      SEQ_STOP_REL: begin
        e.st = SEQ_IDLE;
        done = 1'b1;
      end
      default: e.st = SEQ_IDLE;
    endcase
    return done;
  endfunction

  // Applies one item to the engine and returns the result it produces.
  function automatic rsp_t advance(inout engine_t e, input item_t it);
    rsp_t r;
    logic done;
    int lim;
    r = '0;
    done = 1'b0;
    case (it.req_type)
      REQ_CMD:
        if (e.st == SEQ_IDLE) begin
          e.rd = it.is_read;
          e.dev = it.dev_addr;
          e.regad = it.reg_addr;
          e.left = it.length[LEN_BITS-1:0];
          e.stat = STATUS_OK;
          go(e, SEQ_START_REL);
        end
      REQ_BYTE:
        if (e.st == SEQ_WAIT_BYTE) begin
          e.left = e.left - LEN_BITS'(1);
          send_byte(e, it.wr_byte, BYTE_DATA);
        end
      REQ_TICK:
        if (e.st != SEQ_IDLE && e.st != SEQ_WAIT_BYTE) begin
          lim = (e.ticks == 0) ? 1 : int'(e.ticks);
          e.cnt = e.cnt + 8'd1;
          if (int'(e.cnt) >= lim) done = finish_phase(e, it.sda_in, r);
        end
      default: ;
    endcase
    r.scl_out = e.scl;
    r.sda_out = e.sda;
    r.busy_res = (e.st != SEQ_IDLE);
    r.need_byte = (e.st == SEQ_WAIT_BYTE);
    r.done_res = done;
    r.status = done ? e.stat : STATUS_OK;
    return r;
  endfunction

  function automatic item_t bus_item(input logic [39:0] d, input logic [1:0] u);
    item_t it;
    it.req_type = u;
    it.is_read = d[0];
    it.dev_addr = d[7:1];
    it.reg_addr = d[15:8];
    it.length = d[23:16];
    it.wr_byte = d[31:24];
    it.sda_in = d[32];
    return it;
  endfunction

  function automatic rsp_t bus_result(input logic [15:0] d);
    rsp_t r;
    r.scl_out = d[0];
    r.sda_out = d[1];
    r.busy_res = d[2];
    r.need_byte = d[3];
    r.rd_valid = d[4];
    r.rd_byte = d[12:5];
    r.done_res = d[13];
    r.status = d[15:14];
    return r;
  endfunction

  // Fields that an item does not use are random too.
  function automatic item_t rand_item(input logic [1:0] req);
    item_t it;
    it.req_type = req;
    it.is_read = 1'($urandom_range(0, 1));
    it.dev_addr = 7'($urandom_range(0, 127));
    it.reg_addr = 8'($urandom_range(0, 255));
    it.length = 8'($urandom_range(0, 255));
    it.wr_byte = 8'($urandom_range(0, 255));
    it.sda_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic void push(input item_t it, input bit counted);
    pending_q.push_back(it);
    void'(advance(gen, it));
    if (counted) work_items++;
  endfunction

  task automatic report_field(input string name, input int exp_v, input int act_v);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
  endtask

  // Queues one whole transaction; the target answers on SDA as the fault asks.
  task automatic run_txn(input logic rd, input logic [6:0] dev, input logic [7:0] regad,
                         input logic [7:0] len, input fault_e flt, input int nack_at,
                         input rs_e rs, input int pat, input bit noisy);
    item_t it;
    int sent;
    int lim;
    it = rand_item(REQ_CMD);
    it.is_read = rd;
    it.dev_addr = dev;
    it.reg_addr = regad;
    it.length = len;
    push(it, 1'b1);
    sent = 0;
    while (gen.st != SEQ_IDLE) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: it = rand_item(REQ_UNUSED);
          1: it = rand_item(REQ_CMD);
          default: it = rand_item(gen.st == SEQ_WAIT_BYTE ? REQ_TICK : REQ_BYTE);
        endcase
        push(it, 1'b0);
      end
      if (gen.st == SEQ_WAIT_BYTE) begin
        it = rand_item(REQ_BYTE);
        if (pat >= 0) it.wr_byte = sent[0] ? ~pat[7:0] : pat[7:0];
        push(it, 1'b1);
        sent++;
      end else begin
        it = rand_item(REQ_TICK);
        lim = (gen.ticks == 0) ? 1 : int'(gen.ticks);
        // Only the last tick of a phase has its SDA level looked at.
        if (int'(gen.cnt) + 1 >= lim)
          case (gen.st)
            SEQ_START_REL: it.sda_in = (flt != FLT_BUS_LOW);
            SEQ_START_SDA: it.sda_in = (flt == FLT_NO_PULL);
            SEQ_RSTART_REL:
              if (rs == RS_SKIP_EARLY) it.sda_in = 1'b0;
              else if (rs != RS_RANDOM) it.sda_in = 1'b1;
            SEQ_RSTART_SDA:
              if (rs == RS_CLEAN) it.sda_in = 1'b0;
              else if (rs == RS_SKIP_LATE) it.sda_in = 1'b1;
            SEQ_ACK_HIGH:
              if (gen.kind == BYTE_ADDR_WR) it.sda_in = (flt == FLT_ADDR_NACK);
              else if (gen.kind == BYTE_DATA)
                it.sda_in = (flt == FLT_DATA_NACK && sent > nack_at);
            default: ;
          endcase
        push(it, 1'b1);
      end
    end
  endtask

  task automatic rand_txn();
    logic rd;
    logic [7:0] len;
    fault_e flt;
    int pick;
    rd = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 7) len = 8'($urandom_range(0, 3));
    else if (pick < 9) len = 8'($urandom_range(4, 9));
    else len = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 70) flt = FLT_NONE;
    else if (pick < 78) flt = FLT_BUS_LOW;
    else if (pick < 85) flt = FLT_NO_PULL;
    else if (pick < 92) flt = FLT_ADDR_NACK;
    else flt = FLT_DATA_NACK;
    // Long bursts are kept to writes that the target cuts short.
    if (len > 9) begin
      rd = 1'b0;
      if (flt == FLT_NONE) flt = FLT_DATA_NACK;
    end
    run_txn(rd, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), len, flt,
            $urandom_range(0, 2), rs_e'($urandom_range(0, 3)), -1,
            $urandom_range(0, 3) == 0);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || expect_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [7:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    pred.ticks = v;
    gen.ticks = v;
  endtask

  // Sender: bursts of items with random gaps in between.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur = pending_q.pop_front();
        s_axis_tdata <= {7'b0, cur.sda_in, cur.wr_byte, cur.length, cur.reg_addr,
                         cur.dev_addr, cur.is_read};
        s_axis_tuser <= cur.req_type;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall patterns, with one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (mode_left == 0) begin
        rx_mode <= stall_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(40, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        long_hold_done <= 1'b1;
        hold_left <= 80;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: m_axis_tready <= 1'b1;
          RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: m_axis_tready <= (rx_cyc % 5) != 0;
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Predicts on every accepted item and checks every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        expect_q.push_back(advance(pred, bus_item(s_axis_tdata, s_axis_tuser)));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got = bus_result(m_axis_tdata);
        if (expect_q.size() == 0) begin
          report_field("unexpected item", 0, m_axis_tdata);
        end else begin
          want = expect_q.pop_front();
          if (got.scl_out !== want.scl_out) report_field("scl_out", want.scl_out, got.scl_out);
          if (got.sda_out !== want.sda_out) report_field("sda_out", want.sda_out, got.sda_out);
          if (got.busy_res !== want.busy_res)
            report_field("busy_res", want.busy_res, got.busy_res);
          if (got.need_byte !== want.need_byte)
            report_field("need_byte", want.need_byte, got.need_byte);
          if (got.rd_valid !== want.rd_valid)
            report_field("rd_valid", want.rd_valid, got.rd_valid);
          if (got.rd_byte !== want.rd_byte) report_field("rd_byte", want.rd_byte, got.rd_byte);
          if (got.done_res !== want.done_res)
            report_field("done_res", want.done_res, got.done_res);
          if (got.status !== want.status) report_field("status", want.status, got.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int goal;
    int speeds[4];
    pred = engine_reset();
    gen = engine_reset();
    speeds = '{1, 2, 1, 1};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset speed: stray items while idle and a failed START.
    push(rand_item(REQ_BYTE), 1'b0);
    push(rand_item(REQ_UNUSED), 1'b0);
    push(rand_item(REQ_TICK), 1'b0);
    run_txn(1'b0, 7'h2A, 8'h10, 8'd1, FLT_BUS_LOW, 0, RS_CLEAN, -1, 1'b0);

    set_phase_ticks(8'd1);
    run_txn(1'b0, 7'h7F, 8'hFF, 8'd2, FLT_NONE, 0, RS_CLEAN, 8'hFF, 1'b1);
    run_txn(1'b1, 7'h00, 8'h00, 8'd3, FLT_NONE, 0, RS_CLEAN, -1, 1'b1);
    run_txn(1'b1, 7'h55, 8'hA5, 8'd1, FLT_NONE, 0, RS_SKIP_EARLY, -1, 1'b0);
    run_txn(1'b1, 7'h2A, 8'h5A, 8'd0, FLT_NONE, 0, RS_SKIP_LATE, -1, 1'b0);
    run_txn(1'b0, 7'h11, 8'h22, 8'd1, FLT_NO_PULL, 0, RS_CLEAN, -1, 1'b0);
    run_txn(1'b0, 7'h33, 8'h44, 8'd1, FLT_ADDR_NACK, 0, RS_CLEAN, -1, 1'b0);
    run_txn(1'b1, 7'h66, 8'h77, 8'd2, FLT_ADDR_NACK, 0, RS_CLEAN, -1, 1'b0);
    run_txn(1'b0, 7'h40, 8'h01, 8'd255, FLT_DATA_NACK, 2, RS_CLEAN, -1, 1'b1);
    run_txn(1'b0, 7'h08, 8'h7F, 8'd0, FLT_NONE, 0, RS_CLEAN, -1, 1'b0);

    // A zero setting behaves as one tick per phase.
    set_phase_ticks(8'd0);
    run_txn(1'b0, 7'h3C, 8'hC3, 8'd1, FLT_NONE, 0, RS_CLEAN, -1, 1'b0);

    set_phase_ticks(8'd255);
    run_txn(1'b0, 7'h12, 8'h34, 8'd1, FLT_BUS_LOW, 0, RS_CLEAN, -1, 1'b0);

    foreach (speeds[i]) begin
      set_phase_ticks(8'(speeds[i]));
      goal = work_items + RANDOM_ITEMS / 4;
      while (work_items < goal) rand_txn();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_engine.sv
sv/i2c_master_register_access_core.sv
test/i2c_master_register_access_core_tb.sv
